/* design/polyline_viewport_cull_decimate_unit_assert.svh */
// Assertion macros for the polyline viewport cull and decimate unit.
`ifndef POLYLINE_VIEWPORT_CULL_DECIMATE_UNIT_ASSERT_SVH
`define POLYLINE_VIEWPORT_CULL_DECIMATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define PVCD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PVCD_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVCD_ASSERT(label, clk, rst_n, prop, msg)
`define PVCD_ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

/* design/pvcd_pkg.sv */
// Shared constants, types and register codes of the polyline cull and decimate unit.
package pvcd_pkg;

    localparam int COORD_BITS  = 16;
    localparam int EXT_W       = COORD_BITS + 1;
    localparam int BOX_W       = 15;
    localparam int SPACING_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int NEAR_BITS   = 8;

    localparam logic [BOX_W-1:0]     BOX_WIDTH_RST  = BOX_W'(640);
    localparam logic [BOX_W-1:0]     BOX_HEIGHT_RST = BOX_W'(480);
    localparam logic [SPACING_W-1:0] SPACING_RST    = SPACING_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPACING = 2'd2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [EXT_W-1:0]      t_ext;

    typedef struct packed {
        logic in_box;
        logic crosses;
    } t_class;

    typedef struct packed {
        t_coord     x;
        t_coord     y;
        logic       run_end;
    } t_result;

    typedef struct packed {
        logic    [MAX_RESULTS-1:0] valid;
        t_result [MAX_RESULTS-1:0] slot;
    } t_group;

    // Vertex window: entry 1 is the middle vertex, entry 2 the newest.
    // Only the inside bit of the oldest entry is kept.
    typedef struct packed {
        t_coord     x1;
        t_coord     y1;
        t_coord     x2;
        t_coord     y2;
        logic [2:0] in_box;
        logic [1:0] crossing;
        logic [1:0] fill;
        t_coord     last_x;
        t_coord     last_y;
        logic       run_open;
    } t_window;

endpackage

/* design/pvcd_classify.sv */
// Inside test and straight-through crossing test for an arriving vertex.
module pvcd_classify
    import pvcd_pkg::*;
(
    input  t_coord           i_x,
    input  t_coord           i_y,
    input  t_coord           i_prev_x,
    input  t_coord           i_prev_y,
    input  logic             i_prev_inside,
    input  logic             i_prev_valid,
    input  logic [BOX_W-1:0] i_box_w,
    input  logic [BOX_W-1:0] i_box_h,
    output t_class           o_class
);

    t_ext w_e, h_e;
    t_ext ax, ay, bx, by;
    logic a_rows, b_rows, a_cols, b_cols;
    logic left_right, top_bottom;
    logic ins;

    assign w_e = EXT_W'(i_box_w);
    assign h_e = EXT_W'(i_box_h);
    assign ax  = EXT_W'(i_prev_x);
    assign ay  = EXT_W'(i_prev_y);
    assign bx  = EXT_W'(i_x);
    assign by  = EXT_W'(i_y);

    assign a_rows = !ay[EXT_W-1] && (ay < h_e);
    assign b_rows = !by[EXT_W-1] && (by < h_e);
    assign a_cols = !ax[EXT_W-1] && (ax < w_e);
    assign b_cols = !bx[EXT_W-1] && (bx < w_e);

    assign ins = b_cols && b_rows;

    // Earlier end left of the box and later end right of it, both rows inside;
    // or earlier end above and later end below, both columns inside.
    assign left_right = ax[EXT_W-1] && a_rows && (bx >= w_e) && b_rows;
    assign top_bottom = ay[EXT_W-1] && a_cols && (by >= h_e) && b_cols;

    assign o_class.in_box  = ins;
    assign o_class.crosses = i_prev_valid && !i_prev_inside && !ins &&
                             (left_right || top_bottom);

endmodule

/* design/pvcd_decide.sv */
// Keep, skip and run-marker decisions for one vertex step, with the next window state.
module pvcd_decide
    import pvcd_pkg::*;
(
    input  t_window              i_win,
    input  t_coord               i_x,
    input  t_coord               i_y,
    input  logic                 i_last,
    input  t_class               i_class,
    input  logic [SPACING_W-1:0] i_spacing,
    output t_window              o_win,
    output t_group               o_group
);

    function automatic logic near_f(input t_coord ax, input t_coord ay,
                                    input t_coord bx, input t_coord by,
                                    input logic [SPACING_W-1:0] thr);
        t_ext                    dx;
        t_ext                    dy;
        logic [EXT_W-1:0]        mx;
        logic [EXT_W-1:0]        my;
        logic [2*NEAR_BITS-1:0]  sx;
        logic [2*NEAR_BITS-1:0]  sy;
        logic [2*NEAR_BITS:0]    sum;
        dx  = EXT_W'(ax) - EXT_W'(bx);
        dy  = EXT_W'(ay) - EXT_W'(by);
        mx  = dx[EXT_W-1] ? EXT_W'(-dx) : EXT_W'(dx);
        my  = dy[EXT_W-1] ? EXT_W'(-dy) : EXT_W'(dy);
        sx  = mx[NEAR_BITS-1:0] * mx[NEAR_BITS-1:0];
        sy  = my[NEAR_BITS-1:0] * my[NEAR_BITS-1:0];
        sum = {1'b0, sx} + {1'b0, sy};
        return !(|mx[EXT_W-1:NEAR_BITS]) && !(|my[EXT_W-1:NEAR_BITS]) &&
               (sum <= (2*NEAR_BITS+1)'(thr));
    endfunction

    logic   d_old, d_mid, d_cur;
    logic   near_mid, near_new_le, near_old_le;
    logic   s1_on, s1_emit, s2_on, s2_emit;
    logic   ro1, ro2;
    t_coord le_x1, le_y1;

    assign d_old = |i_win.in_box || |i_win.crossing;
    assign d_mid = i_win.in_box[1] || i_win.in_box[2] || i_class.in_box ||
                   i_win.crossing[1] || i_class.crosses;
    assign d_cur = i_win.in_box[2] || i_class.in_box || i_class.crosses;

    // The newest window vertex is compared against both possible last
    // emitted vertices so the two tests run side by side.
    assign near_mid    = near_f(i_win.x1, i_win.y1, i_win.last_x, i_win.last_y, i_spacing);
    assign near_old_le = near_f(i_win.x2, i_win.y2, i_win.last_x, i_win.last_y, i_spacing);
    assign near_new_le = near_f(i_win.x2, i_win.y2, i_win.x1, i_win.y1, i_spacing);

    assign s1_on = i_win.fill[1];
    assign s2_on = i_last && (i_win.fill != 2'd0);

    always_comb begin
        o_group = '0;
        s1_emit = 1'b0;
        s2_emit = 1'b0;
        ro1     = i_win.run_open;
        le_x1   = i_win.last_x;
        le_y1   = i_win.last_y;
        ro2     = 1'b0;

        // Middle vertex, now that its successor is known.
        if (s1_on) begin
            if (!d_old) begin
                o_group.valid[0]        = i_win.run_open;
                o_group.slot[0].run_end = 1'b1;
                ro1                     = 1'b0;
            end else begin
                s1_emit = !(i_win.run_open && d_mid && near_mid);
                o_group.valid[0]  = s1_emit;
                o_group.slot[0].x = i_win.x1;
                o_group.slot[0].y = i_win.y1;
                if (s1_emit) begin
                    ro1   = 1'b1;
                    le_x1 = i_win.x1;
                    le_y1 = i_win.y1;
                end
            end
        end

        // Newest window vertex, flushed at the end of the polyline.
        ro2 = ro1;
        if (s2_on) begin
            if (!d_mid) begin
                o_group.valid[1]        = ro1;
                o_group.slot[1].run_end = 1'b1;
                ro2                     = 1'b0;
            end else begin
                s2_emit = !(ro1 && d_cur && (s1_emit ? near_new_le : near_old_le));
                o_group.valid[1]  = s2_emit;
                o_group.slot[1].x = i_win.x2;
                o_group.slot[1].y = i_win.y2;
                ro2               = ro2 || s2_emit;
            end
        end

        // Final vertex and the closing marker.
        if (i_last) begin
            if (!d_cur) begin
                o_group.valid[2]        = ro2;
                o_group.slot[2].run_end = 1'b1;
            end else begin
                o_group.valid[2]  = 1'b1;
                o_group.slot[2].x = i_x;
                o_group.slot[2].y = i_y;
            end
            o_group.valid[3]        = d_cur;
            o_group.slot[3].run_end = 1'b1;
        end
    end

    always_comb begin
        if (i_last) begin
            o_win = '0;
        end else begin
            o_win.x1        = i_win.x2;
            o_win.y1        = i_win.y2;
            o_win.x2        = i_x;
            o_win.y2        = i_y;
            o_win.in_box    = {i_class.in_box, i_win.in_box[2:1]};
            o_win.crossing  = {i_class.crosses, i_win.crossing[1]};
            o_win.fill      = (i_win.fill == 2'd3) ? 2'd3 : i_win.fill + 2'd1;
            o_win.last_x    = le_x1;
            o_win.last_y    = le_y1;
            o_win.run_open  = ro1;
        end
    end

endmodule

/* design/pvcd_out_queue.sv */
// Result queue: takes a group and hands results out one per cycle unless stalled.
module pvcd_out_queue
    import pvcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_group  i_group,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result,
    output logic    o_last_result
);

    t_result [MAX_RESULTS-1:0] r_q, n_q;
    logic    [CNT_W-1:0]       r_cnt, n_cnt;
    logic                      pop;

    assign pop           = (r_cnt != '0) && !i_stall;
    assign o_free        = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && !i_stall);
    assign o_valid       = (r_cnt != '0);
    assign o_result      = r_q[0];
    assign o_last_result = (r_cnt == CNT_W'(1));

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
        // A group is loaded only when the queue is empty after this cycle.
        if (i_load) begin
            n_cnt = '0;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (i_group.valid[i]) begin
                    n_q[n_cnt[SLOT_W-1:0]] = i_group.slot[i];
                    n_cnt                  = n_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

/* design/polyline_viewport_cull_decimate_unit.sv */
// A vertex request waits in the input register until the decision logic loads its results
// into the result queue, which can hold it there. Throughput: one vertex per cycle while each
// vertex gives at most one result and the receiver does not stall; a vertex with more results
// holds the next one until they have left, bounded by the one-result-per-cycle output port.
// Reset (synchronous, active low) empties the pipe, clears the vertex window and restores
// the box to 640 by 480 and the spacing threshold to 64.
`include "polyline_viewport_cull_decimate_unit_assert.svh"

module polyline_viewport_cull_decimate_unit
    import pvcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Vertex requests.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_coord                i_point_x,
    input  t_coord                i_point_y,
    input  logic                  i_last_point,
    // Result requests.
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_coord                o_out_x,
    output t_coord                o_out_y,
    output logic                  o_run_end,
    output logic                  o_last_result
);

    // Configuration registers. They are to be written only while the unit is idle; the block
    // itself does not enforce this, so the user must, and the classifier reads them directly.
    logic [BOX_W-1:0]     r_box_w;
    logic [BOX_W-1:0]     r_box_h;
    logic [SPACING_W-1:0] r_spacing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w   <= BOX_WIDTH_RST;
            r_box_h   <= BOX_HEIGHT_RST;
            r_spacing <= SPACING_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOX_WIDTH:   r_box_w   <= i_cfg_data[BOX_W-1:0];
                CFG_BOX_HEIGHT:  r_box_h   <= i_cfg_data[BOX_W-1:0];
                CFG_MIN_SPACING: r_spacing <= i_cfg_data[SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register. It is refilled in the same cycle it hands its vertex
    // to the decision logic, so a new request can enter every cycle while the
    // result queue keeps up.
    logic    r_a_valid;
    t_coord  r_a_x;
    t_coord  r_a_y;
    logic    r_a_last;
    logic    q_free;
    logic    a_fire;
    logic    in_take;

    assign a_fire  = r_a_valid && q_free;
    assign o_stall = r_a_valid && !q_free;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take || a_fire) begin
            r_a_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_x    <= i_point_x;
            r_a_y    <= i_point_y;
            r_a_last <= i_last_point;
        end
    end

    // Window of the previous vertices, their inside bits and crossing bits,
    // the last emitted vertex and whether a run is open.
    t_window r_win;
    t_window n_win;
    t_class  a_class;
    t_group  a_group;

    pvcd_classify u_classify (
        .i_x           (r_a_x),
        .i_y           (r_a_y),
        .i_prev_x      (r_win.x2),
        .i_prev_y      (r_win.y2),
        .i_prev_inside (r_win.in_box[2]),
        .i_prev_valid  (r_win.fill != 2'd0),
        .i_box_w       (r_box_w),
        .i_box_h       (r_box_h),
        .o_class       (a_class)
    );

    // The middle window vertex is decided once its successor is known; the
    // last vertex of a polyline flushes everything still pending and adds
    // the closing marker, then the window starts over.
    pvcd_decide u_decide (
        .i_win     (r_win),
        .i_x       (r_a_x),
        .i_y       (r_a_y),
        .i_last    (r_a_last),
        .i_class   (a_class),
        .i_spacing (r_spacing),
        .o_win     (n_win),
        .o_group   (a_group)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (a_fire) begin
            r_win <= n_win;
        end
    end

    // Up to four results per vertex are queued and offered one per cycle unless stalled.
    t_result q_result;

    pvcd_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (a_fire),
        .i_group       (a_group),
        .i_stall       (i_stall),
        .o_free        (q_free),
        .o_valid       (o_valid),
        .o_result      (q_result),
        .o_last_result (o_last_result)
    );

    assign o_out_x   = q_result.x;
    assign o_out_y   = q_result.y;
    assign o_run_end = q_result.run_end;

    // Terms used by the checks below.
    logic run_ok;
    logic last_fire;
    logic win_clear;
    logic marker_ok;
    logic pipe_idle;

    assign run_ok    = !r_win.run_open || r_win.fill[1];
    assign last_fire = a_fire && r_a_last;
    assign win_clear = (r_win.fill == 2'd0) && !r_win.run_open;
    assign marker_ok = !(o_valid && o_run_end) || ((o_out_x == '0) && (o_out_y == '0));
    assign pipe_idle = !o_valid && !o_stall;

    // A run can only be open once the window has held at least two vertices.
    `PVCD_ASSERT(a_run_needs_window, i_clk, i_rst_n, run_ok, "run open with short window")
    // The final vertex of a polyline leaves the window and run cleared.
    `PVCD_ASSERT(a_last_clears, i_clk, i_rst_n, last_fire |=> win_clear, "window not cleared")
    // A run end marker carries zero coordinates.
    `PVCD_ASSERT(a_marker_zero, i_clk, i_rst_n, marker_ok, "marker with nonzero coordinates")
    // Reset empties both sides of the pipe.
    `PVCD_ASSERT_ANY(a_reset_empty, i_clk, !i_rst_n |=> pipe_idle, "pipe not empty after reset")

endmodule

/* tb/sv/tb_polyline_viewport_cull_decimate_unit.sv */
// Self-checking testbench for the polyline viewport cull and decimate unit.
module tb_polyline_viewport_cull_decimate_unit;
    import pvcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any accepted request before the run is declared hung. The longest
    // legal quiet stretch is the deliberate receiver hold-off below.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES     = 300;
    // Quiet cycles granted after the last expected result before a register write, so
    // that a vertex still sitting in the decision stage has left it.
    localparam int SETTLE_CYCLES   = 4;
    localparam int PHASE_COUNT     = 5;
    localparam int ITEMS_PER_PHASE = 76;
    localparam int PRESSURE_PHASE  = 4;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   run_end;
        logic   last_result;
    } t_vertex_result;

    typedef enum logic [1:0] {
        ROW_VERTEX,
        ROW_CONFIG,
        ROW_DRAIN
    } t_row_kind;

    typedef enum logic [1:0] {
        SHAPE_FINE,
        SHAPE_COARSE,
        SHAPE_CROSSING,
        SHAPE_NOISE
    } t_shape;

    // One line of stimulus: a vertex request, a register write, or a pause until every
    // expected result has been delivered. Vertex rows may carry hand-written results.
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        t_coord                x;
        t_coord                y;
        logic                  last;
        logic                  typed;
        logic [1:0]            typed_n;
        t_vertex_result        r0;
        t_vertex_result        r1;
    } t_stim_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic                  o_stall;
    t_coord                i_point_x    = '0;
    t_coord                i_point_y    = '0;
    logic                  i_last_point = 1'b0;
    logic                  o_valid;
    logic                  i_stall      = 1'b0;
    t_coord                o_out_x;
    t_coord                o_out_y;
    logic                  o_run_end;
    logic                  o_last_result;

    polyline_viewport_cull_decimate_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_last_point  (i_last_point),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_run_end     (o_run_end),
        .o_last_result (o_last_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idling knobs, in percent per cycle, set by the main sequence for each phase.
    int idle_pct  = 0;
    int stall_pct = 0;

    // A long receiver hold-off is requested by bumping holds_asked; the stall driver
    // serves each request once and counts the hold down in its own process.
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Expected results in delivery order, oldest first.
    t_vertex_result pending_results[$];

    // Directed stimulus table.
    t_stim_row directed_rows[$];

    function automatic void add_expected(t_vertex_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void add_directed(t_stim_row row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------------------------
    // Predictor: its own copy of the registers and the three-vertex window.
    // ------------------------------------------------------------------------------------
    int             box_w;
    int             box_h;
    int             spacing_sq;
    int             win_x [3];
    int             win_y [3];
    bit             win_in [3];
    bit             win_cross [2];
    int             win_fill;
    int             emit_x;
    int             emit_y;
    bit             run_open;
    t_vertex_result step_results[$];

    function automatic void clear_window();
        for (int i = 0; i < 3; i++) begin
            win_x[i]  = 0;
            win_y[i]  = 0;
            win_in[i] = 1'b0;
        end
        win_cross[0] = 1'b0;
        win_cross[1] = 1'b0;
        win_fill     = 0;
        emit_x       = 0;
        emit_y       = 0;
        run_open     = 1'b0;
    endfunction

    function automatic bit point_inside(int x, int y);
        return x >= 0 && x < box_w && y >= 0 && y < box_h;
    endfunction

    // Only straight passes are recognized: left of the box to right of it with both rows
    // inside, or above it to below it with both columns inside.
    function automatic bit segment_runs_through(int ax, int ay, int bx, int by);
        int lx;
        int ly;
        lx = box_w - 1;
        ly = box_h - 1;
        if (ax < 0 && bx < 0) return 1'b0;
        if (ax > lx && bx > lx) return 1'b0;
        if (ay > ly && by > ly) return 1'b0;
        if (ay < 0 && by < 0) return 1'b0;
        if (ax < 0 && ay >= 0 && ay <= ly && bx > lx && by >= 0 && by <= ly) return 1'b1;
        if (ay < 0 && ax >= 0 && ax <= lx && by > ly && bx >= 0 && bx <= lx) return 1'b1;
        return 1'b0;
    endfunction

    // A difference beyond 255 on either axis is never close, whatever the threshold.
    function automatic bit close_to_emitted(int x, int y);
        int dx;
        int dy;
        dx = x - emit_x;
        dy = y - emit_y;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx > 255 || dy > 255) return 1'b0;
        return dx * dx + dy * dy <= spacing_sq;
    endfunction

    function automatic void emit(int x, int y, bit marker);
        t_vertex_result r;
        r.x           = t_coord'(x);
        r.y           = t_coord'(y);
        r.run_end     = marker;
        r.last_result = 1'b0;
        step_results.insert(step_results.size(), r);
    endfunction

    function automatic void decide_vertex(int x, int y, bit drawable, bit is_last,
                                          bit next_drawable);
        if (!drawable) begin
            if (run_open) begin
                emit(0, 0, 1'b1);
                run_open = 1'b0;
            end
            return;
        end
        if (run_open && !is_last && next_drawable && close_to_emitted(x, y)) return;
        emit(x, y, 1'b0);
        emit_x   = x;
        emit_y   = y;
        run_open = 1'b1;
    endfunction

    // Advances the predictor by one accepted vertex and leaves its results in step_results.
    function automatic void cull_decimate_step(t_coord px, t_coord py, logic last);
        int             x;
        int             y;
        bit             ins;
        bit             c_new;
        bit             d_old;
        bit             d_mid;
        bit             d_cur;
        bit             d_prev;
        step_results.delete();
        x     = int'(px);
        y     = int'(py);
        ins   = point_inside(x, y);
        c_new = 1'b0;
        if (win_fill >= 1 && !win_in[2] && !ins)
            c_new = segment_runs_through(win_x[2], win_y[2], x, y);
        if (win_fill >= 2) begin
            d_old = win_in[0] || win_in[1] || win_in[2] || win_cross[0] || win_cross[1];
            d_mid = win_in[1] || win_in[2] || ins || win_cross[1] || c_new;
            decide_vertex(win_x[1], win_y[1], d_old, 1'b0, d_mid);
        end
        if (last) begin
            d_cur = win_in[2] || ins || c_new;
            if (win_fill >= 1) begin
                d_prev = win_in[1] || win_in[2] || ins || win_cross[1] || c_new;
                decide_vertex(win_x[2], win_y[2], d_prev, 1'b0, d_cur);
            end
            decide_vertex(x, y, d_cur, 1'b1, 1'b0);
            if (run_open) emit(0, 0, 1'b1);
            clear_window();
        end else begin
            win_x[0]     = win_x[1];
            win_y[0]     = win_y[1];
            win_in[0]    = win_in[1];
            win_x[1]     = win_x[2];
            win_y[1]     = win_y[2];
            win_in[1]    = win_in[2];
            win_x[2]     = x;
            win_y[2]     = y;
            win_in[2]    = ins;
            win_cross[0] = win_cross[1];
            win_cross[1] = c_new;
            if (win_fill < 3) win_fill++;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_result = 1'b1;
    endfunction

    function automatic void write_model_register(logic [CFG_IDX_W-1:0] index,
                                                 logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_BOX_WIDTH:   box_w      = int'(data[BOX_W-1:0]);
            CFG_BOX_HEIGHT:  box_h      = int'(data[BOX_W-1:0]);
            CFG_MIN_SPACING: spacing_sq = int'(data[SPACING_W-1:0]);
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------------------
    // Row builders for the stimulus table.
    // ------------------------------------------------------------------------------------
    function automatic t_vertex_result res(int x, int y, bit run_end, bit last);
        t_vertex_result r;
        r.x           = t_coord'(x);
        r.y           = t_coord'(y);
        r.run_end     = run_end;
        r.last_result = last;
        return r;
    endfunction

    function automatic t_stim_row vertex_row(int x, int y, bit last);
        t_stim_row row;
        row      = '0;
        row.kind = ROW_VERTEX;
        row.x    = t_coord'(x);
        row.y    = t_coord'(y);
        row.last = last;
        return row;
    endfunction

    // A lone closing vertex whose results are written out by hand.
    function automatic t_stim_row typed_row(int x, int y, int n, t_vertex_result r0,
                                            t_vertex_result r1);
        t_stim_row row;
        row         = vertex_row(x, y, 1'b1);
        row.typed   = 1'b1;
        row.typed_n = 2'(n);
        row.r0      = r0;
        row.r1      = r1;
        return row;
    endfunction

    function automatic t_stim_row config_row(logic [CFG_IDX_W-1:0] index, int data);
        t_stim_row row;
        row           = '0;
        row.kind      = ROW_CONFIG;
        row.reg_index = index;
        row.reg_data  = CFG_DATA_W'(data);
        return row;
    endfunction

    function automatic t_stim_row drain_row();
        t_stim_row row;
        row      = '0;
        row.kind = ROW_DRAIN;
        return row;
    endfunction

    // ------------------------------------------------------------------------------------
    // Request driver. Inputs change only at falling edges; acceptance is judged at the
    // rising edge from the stall the block showed just before it.
    // ------------------------------------------------------------------------------------

    // Pause the sender until every expected result has come out, then give a vertex that
    // is still being decided (and has no result of its own) time to leave the pipe.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_row(input t_stim_row row);
        case (row.kind)
            ROW_VERTEX: begin
                @(negedge i_clk);
                // Random sender gaps ahead of the request.
                while (int'($urandom_range(0, 99)) < idle_pct) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                end
                i_valid      <= 1'b1;
                i_point_x    <= row.x;
                i_point_y    <= row.y;
                i_last_point <= row.last;
                // The payload stays put until the block takes the request.
                do @(posedge i_clk); while (o_stall !== 1'b0);
                cull_decimate_step(row.x, row.y, row.last);
                if (row.typed) begin
                    if (row.typed_n >= 1) add_expected(row.r0);
                    if (row.typed_n >= 2) add_expected(row.r1);
                end else begin
                    foreach (step_results[k]) add_expected(step_results[k]);
                end
            end
            ROW_DRAIN: wait_drained();
            ROW_CONFIG: begin
                // Registers change only while the block is idle.
                wait_drained();
                i_cfg_we    <= 1'b1;
                i_cfg_index <= row.reg_index;
                i_cfg_data  <= row.reg_data;
                @(negedge i_clk);
                i_cfg_we <= 1'b0;
                write_model_register(row.reg_index, row.reg_data);
            end
            default: ;
        endcase
    endtask

    // A coordinate spread around [0, extent) with margins on both sides, landing exactly
    // on the box edges now and then.
    function automatic int near_span(int extent);
        int margin;
        margin = extent / 2 + 8;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       return -1;
                1:       return 0;
                2:       return extent - 1;
                default: return extent;
            endcase
        end
        return int'($urandom_range(0, extent + 2 * margin)) - margin;
    endfunction

    function automatic int rand_delta(int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // One whole polyline with random content. Fine walks exercise decimation, coarse
    // walks the cull around the box edges, crossing shapes the straight-through test,
    // and noise puts every coordinate bit through both values.
    task automatic offer_polyline(input int len, input t_shape shape);
        int w;
        int h;
        int x;
        int y;
        bit across;
        w      = box_w;
        h      = box_h;
        across = 1'($urandom_range(0, 1));
        x      = near_span(w);
        y      = near_span(h);
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_FINE: begin
                    if (i > 0) begin
                        x += rand_delta(12);
                        y += rand_delta(12);
                    end
                end
                SHAPE_COARSE: begin
                    if (i > 0) begin
                        x += rand_delta(w / 3 + 2);
                        y += rand_delta(h / 3 + 2);
                    end
                end
                SHAPE_CROSSING: begin
                    if ($urandom_range(0, 4) == 0) begin
                        x = near_span(w);
                        y = near_span(h);
                    end else if (across) begin
                        x = (i % 2 == 0) ? -int'($urandom_range(1, 60))
                                         : w - 1 + int'($urandom_range(1, 60));
                        y = int'($urandom_range(0, h - 1));
                    end else begin
                        y = (i % 2 == 0) ? -int'($urandom_range(1, 60))
                                         : h - 1 + int'($urandom_range(1, 60));
                        x = int'($urandom_range(0, w - 1));
                    end
                end
                default: begin
                    x = int'($urandom);
                    y = int'($urandom);
                end
            endcase
            apply_row(vertex_row(x, y, i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Receiver: stall driver and result checker.
    // ------------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (holds_served != holds_asked) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (int'($urandom_range(0, 99)) < stall_pct);
        end
    end

    // Every accepted result request is matched against the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_vertex_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: out_x=%0d out_y=%0d run_end=%0b",
                       o_out_x, o_out_y, o_run_end);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_x !== want.x) begin
                    $error("out_x: expected %0d, got %0d", want.x, o_out_x);
                    mismatch_count++;
                end
                if (o_out_y !== want.y) begin
                    $error("out_y: expected %0d, got %0d", want.y, o_out_y);
                    mismatch_count++;
                end
                if (o_run_end !== want.run_end) begin
                    $error("run_end: expected %0b, got %0b", want.run_end, o_run_end);
                    mismatch_count++;
                end
                if (o_last_result !== want.last_result) begin
                    $error("last_result: expected %0b, got %0b", want.last_result,
                           o_last_result);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends a run in which neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then randomized phases.
    // ------------------------------------------------------------------------------------
    initial begin : main_sequence
        int        sent;
        int        len;
        int        pick;
        bit        drained_once;
        t_shape    shape;

        box_w      = int'(BOX_WIDTH_RST);
        box_h      = int'(BOX_HEIGHT_RST);
        spacing_sq = int'(SPACING_RST);
        clear_window();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Lone vertices against the reset box of 640 by 480: an inside vertex comes out
        // and is closed by an end marker; an outside one produces nothing.
        add_directed(typed_row(100, 100, 2, res(100, 100, 0, 0), res(0, 0, 1, 1)));
        add_directed(typed_row(-5, 10, 0, res(0, 0, 0, 0), res(0, 0, 0, 0)));
        add_directed(typed_row(32767, 32767, 0, res(0, 0, 0, 0), res(0, 0, 0, 0)));
        add_directed(typed_row(-32768, -32768, 0, res(0, 0, 0, 0), res(0, 0, 0, 0)));
        add_directed(typed_row(0, 0, 2, res(0, 0, 0, 0), res(0, 0, 1, 1)));
        add_directed(typed_row(639, 479, 2, res(639, 479, 0, 0), res(0, 0, 1, 1)));
        add_directed(typed_row(640, 479, 0, res(0, 0, 0, 0), res(0, 0, 0, 0)));
        // Straight pass left to right, then top to bottom, with all ends outside.
        add_directed(vertex_row(-50, 100, 1'b0));
        add_directed(vertex_row(700, 200, 1'b0));
        add_directed(vertex_row(800, 300, 1'b1));
        add_directed(vertex_row(100, -20, 1'b0));
        add_directed(vertex_row(200, 600, 1'b0));
        add_directed(vertex_row(300, 700, 1'b1));
        // Closely spaced vertices inside the box are thinned out.
        add_directed(vertex_row(10, 10, 1'b0));
        add_directed(vertex_row(12, 12, 1'b0));
        add_directed(vertex_row(14, 14, 1'b0));
        add_directed(vertex_row(16, 16, 1'b0));
        add_directed(vertex_row(300, 300, 1'b1));
        // An empty box makes nothing inside.
        add_directed(config_row(CFG_BOX_WIDTH, 0));
        add_directed(vertex_row(5, 5, 1'b0));
        add_directed(vertex_row(6, 6, 1'b1));
        // Bit 15 of the width write falls outside the register; the spare index is inert.
        add_directed(config_row(CFG_BOX_WIDTH, 16'h8000 | 200));
        add_directed(config_row(CFG_SPARE_INDEX, 16'hFFFF));
        // Box change in the middle of a polyline: vertices already classified keep their
        // inside bits while the newer ones see the narrower box.
        add_directed(vertex_row(150, 150, 1'b0));
        add_directed(vertex_row(199, 150, 1'b0));
        add_directed(config_row(CFG_BOX_WIDTH, 100));
        add_directed(vertex_row(180, 150, 1'b0));
        add_directed(vertex_row(50, 50, 1'b1));

        foreach (directed_rows[k]) apply_row(directed_rows[k]);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin
                    apply_row(config_row(CFG_BOX_WIDTH, 640));
                    apply_row(config_row(CFG_BOX_HEIGHT, 480));
                    apply_row(config_row(CFG_MIN_SPACING, 64));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    apply_row(config_row(CFG_BOX_WIDTH, 32767));
                    apply_row(config_row(CFG_BOX_HEIGHT, 32767));
                    apply_row(config_row(CFG_MIN_SPACING, 65535));
                    idle_pct  = 74;
                    stall_pct = 0;
                end
                2: begin
                    apply_row(config_row(CFG_BOX_WIDTH, 1));
                    apply_row(config_row(CFG_BOX_HEIGHT, 1));
                    apply_row(config_row(CFG_MIN_SPACING, 0));
                    idle_pct  = 0;
                    stall_pct = 74;
                end
                3: begin
                    apply_row(config_row(CFG_BOX_WIDTH, $urandom_range(1, 3000)));
                    apply_row(config_row(CFG_BOX_HEIGHT, $urandom_range(1, 3000)));
                    apply_row(config_row(CFG_MIN_SPACING, $urandom_range(0, 4000)));
                    idle_pct  = 6;
                    stall_pct = 6;
                end
                default: begin
                    apply_row(config_row(CFG_BOX_WIDTH, $urandom_range(16, 800)));
                    apply_row(config_row(CFG_BOX_HEIGHT, $urandom_range(16, 800)));
                    apply_row(config_row(CFG_MIN_SPACING, $urandom_range(0, 500)));
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase

            // Back-pressure phase: the receiver holds off for a long stretch while the
            // sender keeps offering, so the block fills up and stalls its input.
            if (phase == PRESSURE_PHASE) holds_asked = holds_asked + 1;

            sent         = 0;
            drained_once = 1'b0;
            while (sent < ITEMS_PER_PHASE) begin
                if (phase == PRESSURE_PHASE && !drained_once && sent >= 40) begin
                    apply_row(drain_row());
                    drained_once = 1'b1;
                end
                len  = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 12));
                pick = int'($urandom_range(0, 99));
                if (pick < 35)
                    shape = SHAPE_FINE;
                else if (pick < 60)
                    shape = SHAPE_COARSE;
                else if (pick < 80)
                    shape = SHAPE_CROSSING;
                else
                    shape = SHAPE_NOISE;
                offer_polyline(len, shape);
                sent += len;
            end
        end

        // Let the last results come out, then give the verdict.
        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
